// File: rtl/core/cmfs_pkg.sv
// Shared types and constants of the cube-map face selector.
// Used by every module and interface of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmfs_pkg;

  localparam int unsigned COMPONENT_BITS = 24;
  localparam int unsigned FRACTION_BITS  = 16;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } cmfs_face_e;

  // Control that rides along with an item through the divider cells.
  typedef struct packed {
    logic       zero;
    cmfs_face_e face;
  } cmfs_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/cmfs_if.sv
// Handshake interfaces for the direction input and the face result.
// Depends on cmfs_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface cmfs_dir_if #(
  parameter int unsigned CB = cmfs_pkg::COMPONENT_BITS
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] dir_x;
  logic signed [CB-1:0] dir_y;
  logic signed [CB-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_res_if #(
  parameter int unsigned FB = cmfs_pkg::FRACTION_BITS
);
  logic          valid;
  logic          ready;
  logic          valid_res;
  logic [2:0]    face;
  logic [FB:0]   u_coord;
  logic [FB:0]   v_coord;

  modport source (output valid, output valid_res, output face, output u_coord,
                  output v_coord, input ready);
  modport sink   (input valid, input valid_res, input face, input u_coord,
                  input v_coord, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cmfs_front.sv
// Input stage: absolute values, major axis, face and the two shifted numerators.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmfs_front #(
  parameter int unsigned CB = cmfs_pkg::COMPONENT_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [CB-1:0]        dir_x_i,
  input  wire logic [CB-1:0]        dir_y_i,
  input  wire logic [CB-1:0]        dir_z_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output cmfs_pkg::cmfs_tag_t       tag_o,
  output logic [CB:0]               num_u_o,
  output logic [CB:0]               num_v_o,
  output logic [CB:0]               div_o
);

  function automatic logic [CB-1:0] mag(input logic [CB-1:0] c);
    mag = c[CB-1] ? (~c + CB'(1)) : c;
  endfunction

  // Returns major + c, or major - c when neg is set; always in [0, 2*major].
  function automatic logic [CB:0] offset(input logic [CB-1:0] m, input logic [CB-1:0] c,
                                         input logic neg);
    logic signed [CB+1:0] cs;
    logic signed [CB+1:0] sum;
    cs     = {{2{c[CB-1]}}, c};
    sum    = $signed({2'b00, m}) + (neg ? -cs : cs);
    offset = sum[CB:0];
  endfunction

  logic [CB-1:0]        ax, ay, az, major;
  cmfs_pkg::cmfs_face_e face;
  logic [CB:0]          nu, nv;

  logic                 valid_q;
  cmfs_pkg::cmfs_tag_t  tag_q;
  logic [CB:0]          num_u_q, num_v_q, div_q;

  always_comb begin
    ax    = mag(dir_x_i);
    ay    = mag(dir_y_i);
    az    = mag(dir_z_i);
    major = ax;
    if (ay > major) begin
      major = ay;
    end
    if (az > major) begin
      major = az;
    end
    if (ax >= ay && ax >= az) begin
      if (!dir_x_i[CB-1]) begin
        face = cmfs_pkg::FACE_PX;
        nu   = offset(major, dir_z_i, 1'b1);
      end else begin
        face = cmfs_pkg::FACE_NX;
        nu   = offset(major, dir_z_i, 1'b0);
      end
      nv = offset(major, dir_y_i, 1'b1);
    end else if (ay >= az) begin
      nu = offset(major, dir_x_i, 1'b0);
      if (!dir_y_i[CB-1]) begin
        face = cmfs_pkg::FACE_PY;
        nv   = offset(major, dir_z_i, 1'b0);
      end else begin
        face = cmfs_pkg::FACE_NY;
        nv   = offset(major, dir_z_i, 1'b1);
      end
    end else begin
      if (!dir_z_i[CB-1]) begin
        face = cmfs_pkg::FACE_PZ;
        nu   = offset(major, dir_x_i, 1'b0);
      end else begin
        face = cmfs_pkg::FACE_NZ;
        nu   = offset(major, dir_x_i, 1'b1);
      end
      nv = offset(major, dir_y_i, 1'b1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_q.zero <= (major == '0);
      tag_q.face <= face;
      num_u_q    <= nu;
      num_v_q    <= nv;
      div_q      <= {major, 1'b0};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// File: rtl/core/cmfs_cell.sv
// One divider cell: a compare and subtract per coordinate, one quotient bit each.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmfs_cell #(
  parameter int unsigned CB = cmfs_pkg::COMPONENT_BITS,
  parameter int unsigned FB = cmfs_pkg::FRACTION_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire cmfs_pkg::cmfs_tag_t  tag_i,
  input  wire logic [CB:0]          rem_u_i,
  input  wire logic [CB:0]          rem_v_i,
  input  wire logic [FB+1:0]        quo_u_i,
  input  wire logic [FB+1:0]        quo_v_i,
  input  wire logic [CB:0]          div_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output cmfs_pkg::cmfs_tag_t       tag_o,
  output logic [CB:0]               rem_u_o,
  output logic [CB:0]               rem_v_o,
  output logic [FB+1:0]             quo_u_o,
  output logic [FB+1:0]             quo_v_o,
  output logic [CB:0]               div_o
);

  logic                bit_u, bit_v;
  logic [CB:0]         diff_u, diff_v;
  logic                valid_q;
  cmfs_pkg::cmfs_tag_t tag_q;
  logic [CB:0]         rem_u_q, rem_v_q, div_q;
  logic [FB+1:0]       quo_u_q, quo_v_q;

  // The remainder after the subtract is below the divisor, so it fits CB bits.
  always_comb begin
    bit_u  = (rem_u_i >= div_i);
    bit_v  = (rem_v_i >= div_i);
    diff_u = bit_u ? (rem_u_i - div_i) : rem_u_i;
    diff_v = bit_v ? (rem_v_i - div_i) : rem_v_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_q   <= tag_i;
      rem_u_q <= {diff_u[CB-1:0], 1'b0};
      rem_v_q <= {diff_v[CB-1:0], 1'b0};
      quo_u_q <= {quo_u_i[FB:0], bit_u};
      quo_v_q <= {quo_v_i[FB:0], bit_v};
      div_q   <= div_i;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// File: rtl/core/cmfs_out.sv
// Output stage: rounds the doubled quotients to the face coordinates and holds the result.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmfs_out #(
  parameter int unsigned FB = cmfs_pkg::FRACTION_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire cmfs_pkg::cmfs_tag_t  tag_i,
  input  wire logic [FB+1:0]        quo_u_i,
  input  wire logic [FB+1:0]        quo_v_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic                      valid_res_o,
  output logic [2:0]                face_o,
  output logic [FB:0]               u_coord_o,
  output logic [FB:0]               v_coord_o
);

  logic [FB+1:0] sum_u, sum_v;
  logic          valid_q, valid_res_q;
  logic [2:0]    face_q;
  logic [FB:0]   u_q, v_q;

  // The quotient carries one extra fraction bit; adding one and dropping it rounds half up.
  assign sum_u = quo_u_i + (FB+2)'(1);
  assign sum_v = quo_v_i + (FB+2)'(1);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      valid_res_q <= !tag_i.zero;
      face_q      <= tag_i.zero ? 3'(cmfs_pkg::FACE_PX) : 3'(tag_i.face);
      u_q         <= tag_i.zero ? '0 : sum_u[FB+1:1];
      v_q         <= tag_i.zero ? '0 : sum_v[FB+1:1];
    end
  end

  assign valid_o     = valid_q;
  assign valid_res_o = valid_res_q;
  assign face_o      = face_q;
  assign u_coord_o   = u_q;
  assign v_coord_o   = v_q;

endmodule

`default_nettype wire

// File: rtl/core/cube_map_face_select.sv
// Cube-map face selector: one input stage, FRACTION_BITS+2 divider cells, one output stage.
// An accepted item is registered in the input stage, in every divider cell and in the output stage.
// Throughput is one item per cycle while results are taken; every cell resolves one quotient bit per coordinate.
// Each stage holds its item while the next is full, so stalls fill bubbles before backing up.
// Reset clears all stage valid flags asynchronously; payload registers are not reset.
// Depends on cmfs_pkg, cmfs_if, cmfs_front, cmfs_cell and cmfs_out.
`timescale 1ns / 1ps
`default_nettype none

module cube_map_face_select #(
  parameter int unsigned COMPONENT_BITS = cmfs_pkg::COMPONENT_BITS,
  parameter int unsigned FRACTION_BITS  = cmfs_pkg::FRACTION_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cmfs_dir_if.sink   dir_i,
  cmfs_res_if.source res_o
);

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned NCELL = FB + 2;

  logic [NCELL:0]      st_valid;
  logic [NCELL:0]      st_ready;
  cmfs_pkg::cmfs_tag_t st_tag   [NCELL+1];
  logic [CB:0]         st_rem_u [NCELL+1];
  logic [CB:0]         st_rem_v [NCELL+1];
  logic [CB:0]         st_div   [NCELL+1];
  logic [FB+1:0]       st_quo_u [NCELL+1];
  logic [FB+1:0]       st_quo_v [NCELL+1];

  assign st_quo_u[0] = '0;
  assign st_quo_v[0] = '0;

  cmfs_front #(
    .CB (CB)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dir_i.valid),
    .ready_o (dir_i.ready),
    .dir_x_i (dir_i.dir_x),
    .dir_y_i (dir_i.dir_y),
    .dir_z_i (dir_i.dir_z),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .tag_o   (st_tag[0]),
    .num_u_o (st_rem_u[0]),
    .num_v_o (st_rem_v[0]),
    .div_o   (st_div[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cmfs_cell #(
      .CB (CB),
      .FB (FB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .tag_i   (st_tag[i]),
      .rem_u_i (st_rem_u[i]),
      .rem_v_i (st_rem_v[i]),
      .quo_u_i (st_quo_u[i]),
      .quo_v_i (st_quo_v[i]),
      .div_i   (st_div[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .tag_o   (st_tag[i+1]),
      .rem_u_o (st_rem_u[i+1]),
      .rem_v_o (st_rem_v[i+1]),
      .quo_u_o (st_quo_u[i+1]),
      .quo_v_o (st_quo_v[i+1]),
      .div_o   (st_div[i+1])
    );
  end

  cmfs_out #(
    .FB (FB)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (st_valid[NCELL]),
    .ready_o     (st_ready[NCELL]),
    .tag_i       (st_tag[NCELL]),
    .quo_u_i     (st_quo_u[NCELL]),
    .quo_v_i     (st_quo_v[NCELL]),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .valid_res_o (res_o.valid_res),
    .face_o      (res_o.face),
    .u_coord_o   (res_o.u_coord),
    .v_coord_o   (res_o.v_coord)
  );

endmodule

`default_nettype wire

// File: rtl/core/cmfs_chk.sv
// Port-level checks on the result channel of the cube-map face selector.
// Depends on cmfs_pkg; bound to cube_map_face_select below.
`timescale 1ns / 1ps
`default_nettype none

module cmfs_chk #(
  parameter int unsigned FB = cmfs_pkg::FRACTION_BITS
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic        valid_res_i,
  input wire logic [2:0]  face_i,
  input wire logic [FB:0] u_i,
  input wire logic [FB:0] v_i
);

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  // A result that was not taken stays in place unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(valid_res_i) && $stable(face_i)
      && $stable(u_i) && $stable(v_i))
    else $error("result changed while stalled");

  // The zero vector reports every field as zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !valid_res_i |-> face_i == 3'(cmfs_pkg::FACE_PX) && u_i == '0 && v_i == '0)
    else $error("zero vector result has nonzero fields");

  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> face_i <= 3'(cmfs_pkg::FACE_NZ))
    else $error("face code out of range");

  // Coordinates never exceed 1.0.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> u_i <= ONE && v_i <= ONE)
    else $error("face coordinate above one");

endmodule

bind cube_map_face_select cmfs_chk #(
  .FB (FRACTION_BITS)
) u_cmfs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .valid_res_i (res_o.valid_res),
  .face_i      (res_o.face),
  .u_i         (res_o.u_coord),
  .v_i         (res_o.v_coord)
);

`default_nettype wire
